// File: hw/rtl/gose_pkg.sv
// ---------------------------------------------------------------------------
// gose_pkg: shared types and constants for the ground outline span extractor
// Result codes, screen geometry, queue sizing and the packet that carries
// the results of one column from the front end to the back end.
// ---------------------------------------------------------------------------
package gose_pkg;

   localparam int ScreenRows = 200;
   localparam logic [7:0] TopRow = 8'(ScreenRows - 1);

   localparam logic [9:0] ColumnsReset = 10'd320;

   localparam logic [1:0] KindHoriz = 2'd0;
   localparam logic [1:0] KindVert  = 2'd1;
   localparam logic [1:0] KindDone  = 2'd2;

   localparam int SlotCount      = 3;
   localparam int QueueDepth     = 2;
   localparam int QueuePtrWidth  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int QueueCntWidth  = $clog2(QueueDepth + 1);

   typedef struct packed {
      logic [1:0]  kind;
      logic [9:0]  column;
      logic [7:0]  row;
      logic [10:0] length;
   } result_type;

   typedef struct packed {
      logic [1:0]                  count;
      result_type [SlotCount-1:0]  slot;
   } packet_type;

endpackage

// File: hw/rtl/gose_front.sv
// ---------------------------------------------------------------------------
// gose_front: sample intake and column classification
// Holds the profile state, classifies each column and packs the results it
// causes into one packet for the queue.
// ---------------------------------------------------------------------------
module gose_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [15:0]          req_height,
   input  logic                 csr_valid,
   input  logic [9:0]           csr_columns,
   output logic                 push_valid,
   input  logic                 push_ready,
   output gose_pkg::packet_type push_data
);

   logic [9:0] columns_ff, columns_in;
   logic [7:0] left_ff, left_in;
   logic [7:0] centre_ff, centre_in;
   logic       run_open_ff, run_open_in;
   logic [9:0] run_start_ff, run_start_in;
   logic [9:0] run_stop_ff, run_stop_in;
   logic [7:0] run_level_ff, run_level_in;
   logic [9:0] count_ff, count_in;
   logic       primed_ff, primed_in;

   logic                    accept;
   logic [7:0]              h;
   logic [7:0]              y0_lc, y0;
   logic                    at_min, extend, emit_old, at_end, flush;
   logic [9:0]              count_next;
   gose_pkg::result_type    cand [4];
   logic [3:0]              cand_valid;
   logic [1:0]              n;
   gose_pkg::packet_type    pkt;

   assign accept    = req_valid && push_ready;
   assign req_ready = push_ready;

   // clamp to the top screen row
   assign h = (req_height > 16'(gose_pkg::TopRow)) ? gose_pkg::TopRow : req_height[7:0];

   assign y0_lc      = (left_ff < centre_ff) ? left_ff : centre_ff;
   assign y0         = (h < y0_lc) ? h : y0_lc;
   assign at_min     = (y0 == centre_ff);
   assign extend     = at_min && run_open_ff && (run_level_ff == centre_ff);
   assign emit_old   = run_open_ff && !extend;
   assign count_next = count_ff + 10'd1;
   assign at_end     = (count_next == columns_ff);
   assign flush      = at_end && at_min;

   always_comb begin
      run_start_in = run_start_ff;
      run_stop_in  = run_stop_ff;
      run_level_in = run_level_ff;
      if (at_min) begin
         run_stop_in = count_ff;
         if (!extend) begin
            run_start_in = count_ff;
            run_level_in = centre_ff;
         end
      end
   end

   always_comb begin
      cand[0] = '{kind: gose_pkg::KindHoriz, column: run_start_ff,
                  row: gose_pkg::TopRow - run_level_ff,
                  length: {1'b0, run_stop_ff - run_start_ff} + 11'd1};
      cand[1] = '{kind: gose_pkg::KindVert, column: count_ff,
                  row: gose_pkg::TopRow - centre_ff,
                  length: {3'b000, centre_ff - y0} + 11'd1};
      cand[2] = '{kind: gose_pkg::KindHoriz, column: run_start_in,
                  row: gose_pkg::TopRow - run_level_in,
                  length: {1'b0, run_stop_in - run_start_in} + 11'd1};
      cand[3] = '{kind: gose_pkg::KindDone, column: '0, row: '0, length: '0};
      cand_valid = {at_end, flush, !at_min, emit_old} & {4{primed_ff}};

      // pack the valid candidates in order; never more than three
      pkt = '0;
      n   = '0;
      for (int i = 0; i < 4; i++) begin
         if (cand_valid[i] && (n != 2'd3)) begin
            pkt.slot[n] = cand[i];
            n = n + 2'd1;
         end
      end
      pkt.count = n;
   end

   assign push_data  = pkt;
   assign push_valid = accept && (n != 2'd0);

   always_comb begin
      columns_in  = csr_valid ? csr_columns : columns_ff;
      left_in     = left_ff;
      centre_in   = centre_ff;
      run_open_in = run_open_ff;
      count_in    = count_ff;
      primed_in   = primed_ff;
      if (accept) begin
         if (!primed_ff) begin
            left_in   = h;
            centre_in = h;
            count_in  = '0;
            primed_in = 1'b1;
         end else begin
            left_in   = centre_ff;
            centre_in = h;
            if (at_end) begin
               run_open_in = 1'b0;
               count_in    = '0;
               primed_in   = 1'b0;
            end else begin
               run_open_in = at_min;
               count_in    = count_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff   <= gose_pkg::ColumnsReset;
         left_ff      <= '0;
         centre_ff    <= '0;
         run_open_ff  <= 1'b0;
         run_start_ff <= '0;
         run_stop_ff  <= '0;
         run_level_ff <= '0;
         count_ff     <= '0;
         primed_ff    <= 1'b0;
      end else begin
         columns_ff  <= columns_in;
         left_ff     <= left_in;
         centre_ff   <= centre_in;
         run_open_ff <= run_open_in;
         count_ff    <= count_in;
         primed_ff   <= primed_in;
         if (accept && primed_ff) begin
            run_start_ff <= run_start_in;
            run_stop_ff  <= run_stop_in;
            run_level_ff <= run_level_in;
         end
      end
   end

endmodule

// File: hw/rtl/gose_queue.sv
// ---------------------------------------------------------------------------
// gose_queue: packet queue between front and back end
// Small register FIFO of column packets.
// ---------------------------------------------------------------------------
module gose_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  gose_pkg::packet_type push_data,
   output logic                 head_valid,
   output gose_pkg::packet_type head_data,
   input  logic                 pop
);

   gose_pkg::packet_type                  entry_ff [gose_pkg::QueueDepth];
   logic [gose_pkg::QueuePtrWidth-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [gose_pkg::QueuePtrWidth-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [gose_pkg::QueueCntWidth-1:0]    fill_ff, fill_in;
   logic                                  do_push, do_pop;

   assign push_ready = (fill_ff != gose_pkg::QueueCntWidth'(gose_pkg::QueueDepth));
   assign head_valid = (fill_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && head_valid;

   function automatic logic [gose_pkg::QueuePtrWidth-1:0] ptr_inc(
      input logic [gose_pkg::QueuePtrWidth-1:0] p);
      if (p == gose_pkg::QueuePtrWidth'(gose_pkg::QueueDepth - 1)) return '0;
      return p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = do_push ? ptr_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) fill_in = fill_ff + 1'b1;
      else if (!do_push && do_pop) fill_in = fill_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// File: hw/rtl/gose_back.sv
// ---------------------------------------------------------------------------
// gose_back: result sequencer
// Walks the slots of the head packet into the output register, one result
// per transfer, and flags the last one of each packet.
// ---------------------------------------------------------------------------
module gose_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  gose_pkg::packet_type head_data,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_kind,
   output logic [9:0]           rsp_column,
   output logic [7:0]           rsp_row,
   output logic [10:0]          rsp_length,
   output logic                 rsp_last_of_step
);

   logic                 valid_ff, valid_in;
   logic [1:0]           pos_ff, pos_in;
   gose_pkg::result_type res_ff;
   logic                 last_ff;
   logic                 load, last;

   assign load = head_valid && (!valid_ff || rsp_ready);
   assign last = (pos_ff == head_data.count - 2'd1);
   assign pop  = load && last;

   always_comb begin
      valid_in = valid_ff;
      pos_in   = pos_ff;
      if (load) begin
         valid_in = 1'b1;
         pos_in   = last ? 2'd0 : pos_ff + 2'd1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pos_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff  <= head_data.slot[pos_ff];
         last_ff <= last;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_kind         = res_ff.kind;
   assign rsp_column       = res_ff.column;
   assign rsp_row          = res_ff.row;
   assign rsp_length       = res_ff.length;
   assign rsp_last_of_step = last_ff;

endmodule

// File: hw/rtl/ground_outline_span_extract.sv
// ---------------------------------------------------------------------------
// ground_outline_span_extract: terrain profile to outline spans
// Path: with the queue and output register empty, a sample's first result
// is written into the queue as the sample transfers, then loaded into the
// output register and offered there. Throughput: one sample per cycle while
// each sample yields at most one result and results are taken; the single
// result channel moves one result per cycle while rsp_ready is high.
// Reset: synchronous; clears profile state and queue, columns returns to 320.
// ---------------------------------------------------------------------------
module ground_outline_span_extract (
   input  logic        clock,
   input  logic        reset,
   // sample channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_height,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [9:0]  rsp_column,
   output logic [7:0]  rsp_row,
   output logic [10:0] rsp_length,
   output logic        rsp_last_of_step,
   // columns register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [9:0]  csr_columns
);

   // Front end: clamps the sample, tracks left/centre heights and the open
   // run, and packs up to three results (old run, vertical step, flush/done)
   // into one packet for each sample that yields a result.
   logic                 push_valid, push_ready;
   gose_pkg::packet_type push_data;

   // Back end reads the head packet slot by slot.
   logic                 head_valid, pop;
   gose_pkg::packet_type head_data;

   // Register writes are always taken; they are to arrive only while idle, which the block itself does not enforce.
   assign csr_ready = 1'b1;

   gose_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_height  (req_height),
      .csr_valid   (csr_valid),
      .csr_columns (csr_columns),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_data   (push_data)
   );

   // Decouples the sample side from the result side so either may stall.
   gose_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop)
   );

   // Output register; the next result loads as the current one transfers.
   gose_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_data        (head_data),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_column       (rsp_column),
      .rsp_row          (rsp_row),
      .rsp_length       (rsp_length),
      .rsp_last_of_step (rsp_last_of_step)
   );

endmodule

// File: hw/rtl/gose_checker.sv
// ---------------------------------------------------------------------------
// gose_checker: port-level checks for the span extractor
// Watches the result channel and the reset behaviour.
// ---------------------------------------------------------------------------
module gose_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_kind,
   input logic [9:0]  rsp_column,
   input logic [7:0]  rsp_row,
   input logic [10:0] rsp_length,
   input logic        rsp_last_of_step
);

   // a result held back stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before transfer");

   // done marker always closes its sample
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == gose_pkg::KindDone) |-> rsp_last_of_step)
      else $error("done marker not last of step");

   // done marker carries zero fields
   a_done_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == gose_pkg::KindDone)
      |-> (rsp_column == '0) && (rsp_row == '0) && (rsp_length == '0))
      else $error("done marker with non-zero fields");

   // spans are never empty
   a_span_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != gose_pkg::KindDone) |-> (rsp_length != '0))
      else $error("zero-length span");

   // nothing offered straight after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind ground_outline_span_extract gose_checker u_gose_checker (.*);
